>>> src/gapv_pkg.sv
// ============================================================================
// gapv_pkg - shared constants for the gimbal axis PID velocity controller
// Field widths, fixed-point format, register map and reset values.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package gapv_pkg;

    // Axis count and fixed-point format
    localparam int NUM_AXES  = 3;
    localparam int FRAC_BITS = 16;

    // Field widths
    localparam int AXIS_W     = 2;
    localparam int DATA_W     = 32;
    localparam int GAIN_W     = 31;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;
    localparam int ACTIVE_W   = 2;

    // Register map
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_DERIV     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_INTEG     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VELOCITY_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_TAU     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_AXES    = 3'd5;

    // Reset values: 8.0, 1.0, 0.1 (rounded), 0.0
    localparam logic [GAIN_W-1:0] RST_GAIN_PROP  = GAIN_W'(8 << FRAC_BITS);
    localparam logic [GAIN_W-1:0] RST_GAIN_DERIV = GAIN_W'(1 << FRAC_BITS);
    localparam logic [GAIN_W-1:0] RST_GAIN_INTEG = GAIN_W'(((1 << FRAC_BITS) + 5) / 10);
    localparam logic [GAIN_W-1:0] RST_ZERO       = '0;
    localparam logic [ACTIVE_W-1:0] RST_ACTIVE_AXES = 2'd1;

endpackage : gapv_pkg

`default_nettype wire

>>> src/gapv_sample_if.sv
// ============================================================================
// gapv_sample_if - measurement word channel
// Valid/ready channel carrying one axis update: angles, rate and time step.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

interface gapv_sample_if;
    import gapv_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [AXIS_W-1:0]        axis;
    logic signed [DATA_W-1:0] target_angle;
    logic signed [DATA_W-1:0] measured_angle;
    logic signed [DATA_W-1:0] measured_rate;
    logic [GAIN_W-1:0]        step_time;

    modport source (
        output valid, axis, target_angle, measured_angle, measured_rate, step_time,
        input  ready
    );

    modport sink (
        input  valid, axis, target_angle, measured_angle, measured_rate, step_time,
        output ready
    );
endinterface : gapv_sample_if

`default_nettype wire

>>> src/gapv_command_if.sv
// ============================================================================
// gapv_command_if - rate command word channel
// Valid/ready channel carrying one commanded joint velocity and its axis.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

interface gapv_command_if;
    import gapv_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [AXIS_W-1:0]        axis_out;
    logic signed [DATA_W-1:0] rate_command;

    modport source (
        output valid, axis_out, rate_command,
        input  ready
    );

    modport sink (
        input  valid, axis_out, rate_command,
        output ready
    );
endinterface : gapv_command_if

`default_nettype wire

>>> src/gimbal_axis_pid_velocity.sv
// ============================================================================
// gimbal_axis_pid_velocity - per-axis PID velocity controller
// Setpoint low-pass, error integral and PID sum for up to NUM_AXES axes,
// computed with a bit-serial shift-add multiplier and a bit-serial divider.
// ============================================================================
// One sample word is processed at a time. A word for an active axis passes
// through six shift-add products, the setpoint divide and the control states
// before its command is loaded, and the next word is accepted once the
// sequencer is back in idle; with step_time + filter_tau equal to zero the
// divide is skipped. The single shift-add multiplier retires one bit of the
// 31-bit gain, time step or filter constant per cycle over six products, and
// the restoring divider of the setpoint filter gives one quotient bit per
// cycle. A word for an inactive axis is dropped in the cycle it is accepted.
// The command register lets a new sample be accepted while the previous
// command waits to be taken. Configuration writes must happen only while the
// block is idle.
`timescale 1ns / 1ps
`default_nettype none

module gimbal_axis_pid_velocity (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    gapv_sample_if.sink                      sample,
    gapv_command_if.source                   command,
    input  wire logic                        cfg_wr_en,
    input  wire logic [gapv_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [gapv_pkg::CFG_DATA_W-1:0] cfg_data
);
    import gapv_pkg::*;

    // Local sizes
    localparam int ACC_W      = 66;
    localparam int ERR_W      = DATA_W + 1;
    localparam int DEN_W      = GAIN_W + 1;
    localparam int MUL_STEPS  = GAIN_W;
    localparam int DIV_STEPS  = DATA_W;
    localparam int CNT_W      = $clog2(DIV_STEPS);
    localparam int AXIS_IDX_W = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
    localparam int AXIS_CMP_W = 4;

    localparam logic signed [ACC_W-1:0] SAT_HI =
        {{(ACC_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_LO =
        {{(ACC_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};

    // Sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_MUL1   = 4'd1;
    localparam logic [3:0] S_MUL2   = 4'd2;
    localparam logic [3:0] S_DIVSET = 4'd3;
    localparam logic [3:0] S_DIV    = 4'd4;
    localparam logic [3:0] S_DIVEND = 4'd5;
    localparam logic [3:0] S_ERR    = 4'd6;
    localparam logic [3:0] S_MUL3   = 4'd7;
    localparam logic [3:0] S_INTEG  = 4'd8;
    localparam logic [3:0] S_MUL4   = 4'd9;
    localparam logic [3:0] S_MUL5   = 4'd10;
    localparam logic [3:0] S_MUL6   = 4'd11;
    localparam logic [3:0] S_CMD    = 4'd12;
    localparam logic [3:0] S_OUT    = 4'd13;

    // Saturate a wide signed value to 32 bits
    function automatic logic [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic [DATA_W-1:0] r;
        if (v > SAT_HI)
            r = SAT_HI[DATA_W-1:0];
        else if (v < SAT_LO)
            r = SAT_LO[DATA_W-1:0];
        else
            r = v[DATA_W-1:0];
        return r;
    endfunction

    // Configuration registers
    logic [GAIN_W-1:0]   gain_prop_reg;
    logic [GAIN_W-1:0]   gain_deriv_reg;
    logic [GAIN_W-1:0]   gain_integ_reg;
    logic [GAIN_W-1:0]   velocity_limit_reg;
    logic [GAIN_W-1:0]   filter_tau_reg;
    logic [ACTIVE_W-1:0] active_axes_reg;

    // Per-axis state
    logic [DATA_W-1:0] filt_arr_reg  [NUM_AXES];
    logic [DATA_W-1:0] integ_arr_reg [NUM_AXES];

    // Control registers
    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;

    // Datapath registers
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [ACC_W-1:0]  mcand_reg, mcand_next;
    logic [GAIN_W-1:0]        mplier_reg, mplier_next;
    logic                     mul_sub_reg, mul_sub_next;
    logic [AXIS_W-1:0]        axis_reg, axis_next;
    logic [DATA_W-1:0]        target_reg, target_next;
    logic [DATA_W-1:0]        meas_reg, meas_next;
    logic [DATA_W-1:0]        rate_reg, rate_next;
    logic [GAIN_W-1:0]        dt_reg, dt_next;
    logic [DEN_W-1:0]         den_reg, den_next;
    logic                     div_neg_reg, div_neg_next;
    logic [DATA_W-1:0]        div_rem_reg, div_rem_next;
    logic [DATA_W-1:0]        div_quo_reg, div_quo_next;
    logic [DATA_W-1:0]        ft_reg, ft_next;
    logic [ERR_W-1:0]         err_reg, err_next;
    logic [DATA_W-1:0]        integ_reg, integ_next;
    logic [DATA_W-1:0]        cmd_reg, cmd_next;
    logic [AXIS_W-1:0]        out_axis_reg, out_axis_next;
    logic [DATA_W-1:0]        out_cmd_reg, out_cmd_next;

    // Combinational helpers
    logic                         accept;
    logic                         axis_ok;
    logic [AXIS_W+AXIS_IDX_W-1:0] axis_wide;
    logic [AXIS_IDX_W-1:0]        axis_idx;
    logic                         mul_last;
    logic                         div_last;
    logic signed [ACC_W-1:0]      acc_step;
    logic signed [ACC_W-1:0]      num_mag;
    logic [DEN_W:0]               div_trial;
    logic [DEN_W:0]               div_diff;
    logic                         div_ge;
    logic [DATA_W-1:0]            ft_div;
    logic [ERR_W-1:0]             err_calc;
    logic signed [ACC_W-1:0]      integ_old_ext;
    logic signed [ACC_W-1:0]      integ_sum;
    logic [DATA_W-1:0]            integ_calc;
    logic [DATA_W-1:0]            cmd_sat;
    logic signed [ERR_W-1:0]      cmd_ext;
    logic signed [ERR_W-1:0]      lim_ext;
    logic signed [ERR_W-1:0]      lim_neg;
    logic                         ft_we;
    logic                         integ_we;

    // Handshake
    assign sample.ready = (state_reg == S_IDLE);
    assign accept       = sample.valid && sample.ready;
    assign axis_ok      = (sample.axis < active_axes_reg) &&
                          ({2'b00, sample.axis} < AXIS_CMP_W'(NUM_AXES));

    assign command.valid        = out_valid_reg;
    assign command.axis_out     = out_axis_reg;
    assign command.rate_command = out_cmd_reg;

    // Axis index into the state arrays
    assign axis_wide = {{AXIS_IDX_W{1'b0}}, axis_reg};
    assign axis_idx  = axis_wide[AXIS_IDX_W-1:0];

    // Shift-add step: one multiplier bit per cycle
    assign mul_last = (cnt_reg == CNT_W'(MUL_STEPS - 1));
    always_comb
    begin
        acc_step = acc_reg;
        if (mplier_reg[0])
        begin
            if (mul_sub_reg)
                acc_step = acc_reg - mcand_reg;
            else
                acc_step = acc_reg + mcand_reg;
        end
    end

    // Restoring divide step: one quotient bit per cycle
    assign div_last  = (cnt_reg == CNT_W'(DIV_STEPS - 1));
    assign num_mag   = acc_reg[ACC_W-1] ? -acc_reg : acc_reg;
    assign div_trial = {div_rem_reg, div_quo_reg[DATA_W-1]};
    assign div_diff  = div_trial - {1'b0, den_reg};
    assign div_ge    = !div_diff[DEN_W];
    assign ft_div    = div_neg_reg ? (~div_quo_reg + 1'b1) : div_quo_reg;

    // Error, integral and command
    assign err_calc      = {ft_reg[DATA_W-1], ft_reg} - {meas_reg[DATA_W-1], meas_reg};
    assign integ_old_ext = {{(ACC_W-DATA_W){integ_arr_reg[axis_idx][DATA_W-1]}},
                            integ_arr_reg[axis_idx]};
    assign integ_sum     = integ_old_ext + (acc_reg >>> FRAC_BITS);
    assign integ_calc    = sat32(integ_sum);
    assign cmd_sat       = sat32(acc_reg >>> FRAC_BITS);
    assign cmd_ext       = {cmd_sat[DATA_W-1], cmd_sat};
    assign lim_ext       = {2'b00, velocity_limit_reg};
    assign lim_neg       = -lim_ext;

    // Sequencer and datapath next state
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        acc_next       = acc_reg;
        mcand_next     = mcand_reg;
        mplier_next    = mplier_reg;
        mul_sub_next   = mul_sub_reg;
        axis_next      = axis_reg;
        target_next    = target_reg;
        meas_next      = meas_reg;
        rate_next      = rate_reg;
        dt_next        = dt_reg;
        den_next       = den_reg;
        div_neg_next   = div_neg_reg;
        div_rem_next   = div_rem_reg;
        div_quo_next   = div_quo_reg;
        ft_next        = ft_reg;
        err_next       = err_reg;
        integ_next     = integ_reg;
        cmd_next       = cmd_reg;
        out_axis_next  = out_axis_reg;
        out_cmd_next   = out_cmd_reg;
        ft_we          = 1'b0;
        integ_we       = 1'b0;

        // Command register drains independently
        if (out_valid_reg && command.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept && axis_ok)
                begin
                    axis_next    = sample.axis;
                    target_next  = sample.target_angle;
                    meas_next    = sample.measured_angle;
                    rate_next    = sample.measured_rate;
                    dt_next      = sample.step_time;
                    den_next     = {1'b0, sample.step_time} + {1'b0, filter_tau_reg};
                    acc_next     = '0;
                    mcand_next   = {{(ACC_W-DATA_W){sample.target_angle[DATA_W-1]}},
                                    sample.target_angle};
                    mplier_next  = sample.step_time;
                    mul_sub_next = 1'b0;
                    cnt_next     = '0;
                    state_next   = S_MUL1;
                end
            end

            // dt * target
            S_MUL1:
            begin
                acc_next    = acc_step;
                mcand_next  = mcand_reg <<< 1;
                mplier_next = mplier_reg >> 1;
                cnt_next    = cnt_reg + 1'b1;
                if (mul_last)
                begin
                    mcand_next  = {{(ACC_W-DATA_W){filt_arr_reg[axis_idx][DATA_W-1]}},
                                   filt_arr_reg[axis_idx]};
                    mplier_next = filter_tau_reg;
                    cnt_next    = '0;
                    state_next  = S_MUL2;
                end
            end

            // + tau * filtered target
            S_MUL2:
            begin
                acc_next    = acc_step;
                mcand_next  = mcand_reg <<< 1;
                mplier_next = mplier_reg >> 1;
                cnt_next    = cnt_reg + 1'b1;
                if (mul_last)
                begin
                    cnt_next = '0;
                    if (den_reg == '0)
                    begin
                        ft_next    = target_reg;
                        ft_we      = 1'b1;
                        state_next = S_ERR;
                    end
                    else
                        state_next = S_DIVSET;
                end
            end

            // Split numerator magnitude; the high half is already below den
            S_DIVSET:
            begin
                div_neg_next = acc_reg[ACC_W-1];
                div_rem_next = num_mag[2*DATA_W-1:DATA_W];
                div_quo_next = num_mag[DATA_W-1:0];
                cnt_next     = '0;
                state_next   = S_DIV;
            end

            S_DIV:
            begin
                div_rem_next = div_ge ? div_diff[DATA_W-1:0] : div_trial[DATA_W-1:0];
                div_quo_next = {div_quo_reg[DATA_W-2:0], div_ge};
                cnt_next     = cnt_reg + 1'b1;
                if (div_last)
                    state_next = S_DIVEND;
            end

            // Truncate toward zero: apply the numerator sign
            S_DIVEND:
            begin
                ft_next    = ft_div;
                ft_we      = 1'b1;
                state_next = S_ERR;
            end

            S_ERR:
            begin
                err_next     = err_calc;
                acc_next     = '0;
                mcand_next   = {{(ACC_W-ERR_W){err_calc[ERR_W-1]}}, err_calc};
                mplier_next  = dt_reg;
                mul_sub_next = 1'b0;
                cnt_next     = '0;
                state_next   = S_MUL3;
            end

            // dt * err
            S_MUL3:
            begin
                acc_next    = acc_step;
                mcand_next  = mcand_reg <<< 1;
                mplier_next = mplier_reg >> 1;
                cnt_next    = cnt_reg + 1'b1;
                if (mul_last)
                begin
                    cnt_next   = '0;
                    state_next = S_INTEG;
                end
            end

            // Integral update, then start kp * err
            S_INTEG:
            begin
                integ_next   = integ_calc;
                integ_we     = 1'b1;
                acc_next     = '0;
                mcand_next   = {{(ACC_W-ERR_W){err_reg[ERR_W-1]}}, err_reg};
                mplier_next  = gain_prop_reg;
                mul_sub_next = 1'b0;
                cnt_next     = '0;
                state_next   = S_MUL4;
            end

            // kp * err
            S_MUL4:
            begin
                acc_next    = acc_step;
                mcand_next  = mcand_reg <<< 1;
                mplier_next = mplier_reg >> 1;
                cnt_next    = cnt_reg + 1'b1;
                if (mul_last)
                begin
                    mcand_next   = {{(ACC_W-DATA_W){rate_reg[DATA_W-1]}}, rate_reg};
                    mplier_next  = gain_deriv_reg;
                    mul_sub_next = 1'b1;
                    cnt_next     = '0;
                    state_next   = S_MUL5;
                end
            end

            // - kd * rate
            S_MUL5:
            begin
                acc_next    = acc_step;
                mcand_next  = mcand_reg <<< 1;
                mplier_next = mplier_reg >> 1;
                cnt_next    = cnt_reg + 1'b1;
                if (mul_last)
                begin
                    mcand_next   = {{(ACC_W-DATA_W){integ_reg[DATA_W-1]}}, integ_reg};
                    mplier_next  = gain_integ_reg;
                    mul_sub_next = 1'b0;
                    cnt_next     = '0;
                    state_next   = S_MUL6;
                end
            end

            // + ki * integral
            S_MUL6:
            begin
                acc_next    = acc_step;
                mcand_next  = mcand_reg <<< 1;
                mplier_next = mplier_reg >> 1;
                cnt_next    = cnt_reg + 1'b1;
                if (mul_last)
                begin
                    cnt_next   = '0;
                    state_next = S_CMD;
                end
            end

            // Floor, saturate, then clamp to the velocity limit
            S_CMD:
            begin
                cmd_next = cmd_sat;
                if (velocity_limit_reg != '0)
                begin
                    if (cmd_ext > lim_ext)
                        cmd_next = lim_ext[DATA_W-1:0];
                    else if (cmd_ext < lim_neg)
                        cmd_next = lim_neg[DATA_W-1:0];
                end
                state_next = S_OUT;
            end

            // Wait for the command register to be free
            S_OUT:
            begin
                if (!out_valid_reg || command.ready)
                begin
                    out_valid_next = 1'b1;
                    out_axis_next  = axis_reg;
                    out_cmd_next   = cmd_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath payload
    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        mcand_reg    <= mcand_next;
        mplier_reg   <= mplier_next;
        mul_sub_reg  <= mul_sub_next;
        axis_reg     <= axis_next;
        target_reg   <= target_next;
        meas_reg     <= meas_next;
        rate_reg     <= rate_next;
        dt_reg       <= dt_next;
        den_reg      <= den_next;
        div_neg_reg  <= div_neg_next;
        div_rem_reg  <= div_rem_next;
        div_quo_reg  <= div_quo_next;
        ft_reg       <= ft_next;
        err_reg      <= err_next;
        integ_reg    <= integ_next;
        cmd_reg      <= cmd_next;
        out_axis_reg <= out_axis_next;
        out_cmd_reg  <= out_cmd_next;
    end

    // Per-axis filter and integral state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                filt_arr_reg[i]  <= '0;
                integ_arr_reg[i] <= '0;
            end
        end
        else
        begin
            if (ft_we)
                filt_arr_reg[axis_idx] <= ft_next;
            if (integ_we)
                integ_arr_reg[axis_idx] <= integ_calc;
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_prop_reg      <= RST_GAIN_PROP;
            gain_deriv_reg     <= RST_GAIN_DERIV;
            gain_integ_reg     <= RST_GAIN_INTEG;
            velocity_limit_reg <= RST_ZERO;
            filter_tau_reg     <= RST_ZERO;
            active_axes_reg    <= RST_ACTIVE_AXES;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_GAIN_PROP:      gain_prop_reg      <= cfg_data;
                REG_GAIN_DERIV:     gain_deriv_reg     <= cfg_data;
                REG_GAIN_INTEG:     gain_integ_reg     <= cfg_data;
                REG_VELOCITY_LIMIT: velocity_limit_reg <= cfg_data;
                REG_FILTER_TAU:     filter_tau_reg     <= cfg_data;
                REG_ACTIVE_AXES:    active_axes_reg    <= cfg_data[ACTIVE_W-1:0];
                default:            ;
            endcase
        end
    end

    // Assertions
    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && !accept) |=> (state_reg == S_IDLE))
        else $error("sequencer left idle without an accepted word");

    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> ({1'b0, div_rem_reg} < den_reg))
        else $error("divider remainder not below divisor");

    a_quo_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIVEND) |->
            (!div_quo_reg[DATA_W-1] || (div_neg_reg && div_quo_reg[DATA_W-2:0] == '0)))
        else $error("filter quotient out of 32-bit range");

    a_cmd_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && velocity_limit_reg != '0) |->
            ($signed({out_cmd_reg[DATA_W-1], out_cmd_reg}) <= lim_ext &&
             $signed({out_cmd_reg[DATA_W-1], out_cmd_reg}) >= lim_neg))
        else $error("command exceeds velocity limit");

endmodule : gimbal_axis_pid_velocity

`default_nettype wire
